// File: hdl/stqs_pkg.sv
`default_nettype none

package stqs_pkg;

  localparam int MAX_TILES_ACROSS_DEF = 8;
  localparam int MAX_TILES_DOWN_DEF   = 8;

  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 14;
  localparam int IN_TDATA_W   = 120;
  localparam int OUT_TDATA_W  = 208;

  // 1.0 in 1.16 texture format
  localparam logic [16:0] TEX_ONE = 17'h10000;

  typedef enum logic [2:0] {
    REG_TILE_WIDTH_LOG2  = 3'd0,
    REG_TILE_HEIGHT_LOG2 = 3'd1,
    REG_TILES_ACROSS     = 3'd2,
    REG_IMAGE_WIDTH      = 3'd3,
    REG_IMAGE_HEIGHT     = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [3:0]  tile_width_log2;
    logic [3:0]  tile_height_log2;
    logic [3:0]  tiles_across;
    logic [13:0] image_width;
    logic [13:0] image_height;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_W,
    ST_MUL_H,
    ST_MUL_XOFF,
    ST_MUL_YOFF,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul_w;
    logic mul_h;
    logic mul_xoff;
    logic mul_yoff;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic out_free;
    logic last;
  } status_t;

endpackage

`default_nettype wire

// File: hdl/stqs_regs.sv
`default_nettype none

module stqs_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [stqs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [stqs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output stqs_pkg::cfg_t                          cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tile_width_log2  <= 4'd8;
      cfg.tile_height_log2 <= 4'd8;
      cfg.tiles_across     <= 4'd1;
      cfg.image_width      <= 14'd256;
      cfg.image_height     <= 14'd256;
    end else if (cfg_valid && cfg_ready) begin
      case (stqs_pkg::reg_index_t'(cfg_index))
        stqs_pkg::REG_TILE_WIDTH_LOG2:  cfg.tile_width_log2  <= cfg_data[3:0];
        stqs_pkg::REG_TILE_HEIGHT_LOG2: cfg.tile_height_log2 <= cfg_data[3:0];
        stqs_pkg::REG_TILES_ACROSS:     cfg.tiles_across     <= cfg_data[3:0];
        stqs_pkg::REG_IMAGE_WIDTH:      cfg.image_width      <= cfg_data;
        stqs_pkg::REG_IMAGE_HEIGHT:     cfg.image_height     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/stqs_ctrl.sv
`default_nettype none

module stqs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire stqs_pkg::status_t status,
  output stqs_pkg::cmd_t         cmd
);

  stqs_pkg::state_t state;
  stqs_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stqs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      stqs_pkg::ST_IDLE: begin
        if (in_valid) state_next = stqs_pkg::ST_PREP;
      end
      stqs_pkg::ST_PREP: begin
        state_next = status.empty ? stqs_pkg::ST_IDLE : stqs_pkg::ST_MUL_W;
      end
      stqs_pkg::ST_MUL_W:    state_next = stqs_pkg::ST_MUL_H;
      stqs_pkg::ST_MUL_H:    state_next = stqs_pkg::ST_MUL_XOFF;
      stqs_pkg::ST_MUL_XOFF: state_next = stqs_pkg::ST_MUL_YOFF;
      stqs_pkg::ST_MUL_YOFF: state_next = stqs_pkg::ST_EMIT;
      stqs_pkg::ST_EMIT: begin
        if (status.out_free && status.last) state_next = stqs_pkg::ST_IDLE;
      end
      default: state_next = stqs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      stqs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      stqs_pkg::ST_PREP:     cmd.prep     = 1'b1;
      stqs_pkg::ST_MUL_W:    cmd.mul_w    = 1'b1;
      stqs_pkg::ST_MUL_H:    cmd.mul_h    = 1'b1;
      stqs_pkg::ST_MUL_XOFF: cmd.mul_xoff = 1'b1;
      stqs_pkg::ST_MUL_YOFF: cmd.mul_yoff = 1'b1;
      stqs_pkg::ST_EMIT:     cmd.push     = status.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/stqs_dp.sv
`default_nettype none

module stqs_dp #(
  parameter int MAX_TILES_ACROSS = stqs_pkg::MAX_TILES_ACROSS_DEF,
  parameter int MAX_TILES_DOWN   = stqs_pkg::MAX_TILES_DOWN_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire stqs_pkg::cfg_t                     cfg,
  input  wire stqs_pkg::cmd_t                     cmd,
  output stqs_pkg::status_t                       status,
  input  wire logic [stqs_pkg::IN_TDATA_W-1:0]    in_data,
  input  wire logic                               in_mirror,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [stqs_pkg::OUT_TDATA_W-1:0]        out_data,
  output logic                                    out_last
);

  localparam int COL_W = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int ROW_W = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
  localparam logic [14:0] COL_LIM = 15'(MAX_TILES_ACROSS - 1);
  localparam logic [14:0] ROW_LIM = 15'(MAX_TILES_DOWN - 1);

  // latched request
  logic [15:0] dx_r, dy_r, xs_r, ys_r;
  logic [13:0] sx_r, sy_r, sw_r, sh_r;
  logic        mir_r;

  // setup results
  logic [13:0] sw_e, sh_e;
  logic [14:0] ex, ey;
  logic [15:0] xoff, yoff;
  logic [16:0] tl0, tt0, tr1, tb1;
  logic [31:0] twxs, thys;
  logic [14:0] dc, dr;
  logic [COL_W-1:0] ncol_m1;
  logic [ROW_W-1:0] nrow_m1;
  logic [5:0]  c0_lo, r0_lo;
  logic [31:0] fullw, fullh, xoffxs, base_m;

  // walk state
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [31:0] acc_x, acc_xn, acc_y, acc_yn;

  // combinational helpers
  logic [15:0] tw, th, xmask, ymask, sxm, sym, exm, eym;
  logic [13:0] sw_sel, sh_sel;
  logic        full_img;
  logic [31:0] tl_sh, tt_sh;
  logic [32:0] tr_sh, tb_sh;
  logic [14:0] c0_n, c1_n, r0_n, r1_n, dc_n, dr_n;
  logic [15:0] mul_a, mul_b;
  logic [31:0] mul_p;
  logic [31:0] dx32, dy32;

  assign tw    = 16'd1 << cfg.tile_width_log2;
  assign th    = 16'd1 << cfg.tile_height_log2;
  assign xmask = tw - 16'd1;
  assign ymask = th - 16'd1;
  assign sxm   = {2'b00, sx_r} & xmask;
  assign sym   = {2'b00, sy_r} & ymask;
  assign exm   = {1'b0, ex} & xmask;
  assign eym   = {1'b0, ey} & ymask;

  assign full_img = (sw_r == 14'd0) || (sh_r == 14'd0);
  assign sw_sel   = full_img ? cfg.image_width : sw_r;
  assign sh_sel   = full_img ? cfg.image_height : sh_r;

  assign tl_sh = {sxm, 16'd0} >> cfg.tile_width_log2;
  assign tt_sh = {sym, 16'd0} >> cfg.tile_height_log2;
  assign tr_sh = {17'(exm) + 17'd1, 16'd0} >> cfg.tile_width_log2;
  assign tb_sh = {17'(eym) + 17'd1, 16'd0} >> cfg.tile_height_log2;

  assign c0_n = {1'b0, sx_r} >> cfg.tile_width_log2;
  assign r0_n = {1'b0, sy_r} >> cfg.tile_height_log2;
  assign c1_n = ex >> cfg.tile_width_log2;
  assign r1_n = ey >> cfg.tile_height_log2;
  assign dc_n = c1_n - c0_n;
  assign dr_n = r1_n - r0_n;

  assign dx32 = {{8{dx_r[15]}}, dx_r, 8'd0};
  assign dy32 = {{8{dy_r[15]}}, dy_r, 8'd0};

  // one shared multiplier, operands picked by the setup step
  always_comb begin
    mul_a = {2'b00, sw_e};
    mul_b = xs_r;
    if (cmd.mul_h) begin
      mul_a = {2'b00, sh_e};
      mul_b = ys_r;
    end else if (cmd.mul_xoff) begin
      mul_a = xoff;
      mul_b = xs_r;
    end else if (cmd.mul_yoff) begin
      mul_a = yoff;
      mul_b = ys_r;
    end
  end
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r  <= in_data[15:0];
      dy_r  <= in_data[31:16];
      sx_r  <= in_data[45:32];
      sy_r  <= in_data[59:46];
      sw_r  <= in_data[73:60];
      sh_r  <= in_data[87:74];
      xs_r  <= in_data[103:88];
      ys_r  <= in_data[119:104];
      mir_r <= in_mirror;
    end
    if (cmd.prep) begin
      sw_e <= sw_sel;
      sh_e <= sh_sel;
      ex   <= 15'(sx_r) + 15'(sw_sel) - 15'd1;
      ey   <= 15'(sy_r) + 15'(sh_sel) - 15'd1;
      xoff <= tw - sxm;
      yoff <= th - sym;
      tl0  <= tl_sh[16:0];
      tt0  <= tt_sh[16:0];
      twxs <= 32'(xs_r) << cfg.tile_width_log2;
      thys <= 32'(ys_r) << cfg.tile_height_log2;
    end
    if (cmd.mul_w) begin
      fullw   <= mul_p;
      tr1     <= tr_sh[16:0];
      tb1     <= tb_sh[16:0];
      dc      <= dc_n;
      dr      <= dr_n;
      ncol_m1 <= (dc_n > COL_LIM) ? COL_W'(COL_LIM) : dc_n[COL_W-1:0];
      nrow_m1 <= (dr_n > ROW_LIM) ? ROW_W'(ROW_LIM) : dr_n[ROW_W-1:0];
      c0_lo   <= c0_n[5:0];
      r0_lo   <= r0_n[5:0];
    end
    if (cmd.mul_h) begin
      fullh  <= mul_p;
      base_m <= dx32 + fullw;
    end
    if (cmd.mul_xoff) begin
      xoffxs <= mul_p;
    end
  end

  // quad for the current tile
  logic        col_end, row_end, col_first, row_first, quad_last;
  logic [31:0] x2off, y2off, scr_l, scr_r, scr_t, scr_b;
  logic [16:0] t_l, t_r, t_t, t_b, t_left, t_right;
  logic [5:0]  u6, v6, tile_idx;
  logic [9:0]  tprod;

  assign col_first = (col == '0);
  assign row_first = (row == '0);
  assign col_end   = (15'(col) == dc);
  assign row_end   = (15'(row) == dr);
  assign quad_last = (col == ncol_m1) && (row == nrow_m1);

  assign x2off = col_end ? fullw : acc_xn;
  assign y2off = row_end ? fullh : acc_yn;

  // mirroring reflects the left and right screen edges inside the drawn rectangle
  assign scr_l = mir_r ? (base_m - x2off) : (dx32 + acc_x);
  assign scr_r = mir_r ? (base_m - acc_x) : (dx32 + x2off);
  assign scr_t = dy32 + acc_y;
  assign scr_b = dy32 + y2off;

  assign t_l     = col_first ? tl0 : 17'd0;
  assign t_r     = col_end ? tr1 : stqs_pkg::TEX_ONE;
  assign t_t     = row_first ? tt0 : 17'd0;
  assign t_b     = row_end ? tb1 : stqs_pkg::TEX_ONE;
  assign t_left  = mir_r ? t_r : t_l;
  assign t_right = mir_r ? t_l : t_r;

  assign u6       = c0_lo + 6'(col);
  assign v6       = r0_lo + 6'(row);
  assign tprod    = 10'(v6) * 10'(cfg.tiles_across);
  assign tile_idx = tprod[5:0] + u6;

  always_ff @(posedge clk) begin
    if (cmd.mul_yoff) begin
      col    <= '0;
      row    <= '0;
      acc_x  <= 32'd0;
      acc_xn <= xoffxs;
      acc_y  <= 32'd0;
      acc_yn <= mul_p;
    end else if (cmd.push) begin
      if (col == ncol_m1) begin
        col    <= '0;
        row    <= row + ROW_W'(1);
        acc_x  <= 32'd0;
        acc_xn <= xoffxs;
        acc_y  <= acc_yn;
        acc_yn <= acc_yn + thys;
      end else begin
        col    <= col + COL_W'(1);
        acc_x  <= acc_xn;
        acc_xn <= acc_xn + twxs;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data <= {6'd0, scr_b, scr_t, scr_r, scr_l, t_b, t_t, t_right, t_left, tile_idx};
      out_last <= quad_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.empty    = (sw_sel == 14'd0) || (sh_sel == 14'd0);
  assign status.out_free = !out_valid || out_ready;
  assign status.last     = quad_last;

endmodule

`default_nettype wire

// File: hdl/sprite_tile_quad_splitter_unit.sv
`default_nettype none

// Splits one sprite draw request into one screen quad per texture tile that the
// source rectangle covers, up to MAX_TILES_ACROSS by MAX_TILES_DOWN tiles, in
// row order, with tlast on the final quad. After a request is taken the block
// works out the rectangle geometry and then, in turn, the products sw*x_scale,
// sh*y_scale and the first-tile offsets, all through a single shared 16x16
// multiplier; it then hands out one quad per cycle while the output is taken.
// No quad comes out for zero src_w or src_h with zero image width or height.
// The next request is taken as soon as the last quad sits in the output register.
// Configuration registers are written through the cfg channel, which is always
// ready; writes to indexes past the register list are dropped.
module sprite_tile_quad_splitter_unit #(
  parameter int MAX_TILES_ACROSS = stqs_pkg::MAX_TILES_ACROSS_DEF,
  parameter int MAX_TILES_DOWN   = stqs_pkg::MAX_TILES_DOWN_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // dest_x, dest_y, src_x, src_y, src_w, src_h, x_scale, y_scale
  input  wire logic [stqs_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // mirror
  input  wire logic [0:0]                         s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tile_index, tex_left, tex_right, tex_top, tex_bottom, screen_left,
  // screen_right, screen_top, screen_bottom, zero pad
  output logic [stqs_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                    m_axis_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [stqs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [stqs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  stqs_pkg::cfg_t    cfg;
  stqs_pkg::cmd_t    cmd;
  stqs_pkg::status_t status;

  stqs_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stqs_dp #(
    .MAX_TILES_ACROSS (MAX_TILES_ACROSS),
    .MAX_TILES_DOWN   (MAX_TILES_DOWN)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .in_data   (s_axis_tdata),
    .in_mirror (s_axis_tuser[0]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
